// ===== hdl/mlrq_pkg.sv =====
// package: shared constants, codes and types for the multilevel ring queue block
package mlrq_pkg;

  // fixed field widths
  localparam int OP_W      = 3;
  localparam int QSEL_W    = 3;
  localparam int ID_W      = 31;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;

  // default geometry
  localparam int QUEUES_DEF = 5;
  localparam int DEPTH_DEF  = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK_F = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_R = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // request payload
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [QSEL_W-1:0] queue_sel;
    logic [ID_W-1:0]   proc_id;
  } req_t;

  // result payload
  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [ID_W-1:0]      id_out;
    logic [CNT_OUT_W-1:0] count_out;
  } rsp_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SCAN,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

endpackage

// ===== hdl/mlrq_if.sv =====
// interfaces: request and result channels with valid/ready handshake
interface mlrq_req_if;
  import mlrq_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [QSEL_W-1:0] queue_sel;
  logic [ID_W-1:0]   proc_id;

  modport source (output valid, op, queue_sel, proc_id, input ready);
  modport sink   (input valid, op, queue_sel, proc_id, output ready);
endinterface

interface mlrq_rsp_if;
  import mlrq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [ID_W-1:0]      id_out;
  logic [CNT_OUT_W-1:0] count_out;

  modport source (output valid, status, id_out, count_out, input ready);
  modport sink   (input valid, status, id_out, count_out, output ready);
endinterface

// ===== hdl/mlrq_store.sv =====
// module: id storage for all queues, one write port and one registered read port
module mlrq_store #(
  parameter int   ENTRIES = mlrq_pkg::QUEUES_DEF * mlrq_pkg::DEPTH_DEF,
  localparam int  AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [mlrq_pkg::ID_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [mlrq_pkg::ID_W-1:0] wr_data
);
  import mlrq_pkg::*;

  logic [ID_W-1:0] mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/mlrq_seq.sv =====
// module: sequencer with per-queue pointers, shared compare and pointer step unit
module mlrq_seq #(
  parameter int  QUEUES = mlrq_pkg::QUEUES_DEF,
  parameter int  DEPTH  = mlrq_pkg::DEPTH_DEF,
  localparam int AW     = (QUEUES * DEPTH > 1) ? $clog2(QUEUES * DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mlrq_pkg::req_t            in_req,
  output logic                      done,
  output mlrq_pkg::rsp_t            res,
  input  logic                      res_take,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic [mlrq_pkg::ID_W-1:0] rd_data,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [mlrq_pkg::ID_W-1:0] wr_data
);
  import mlrq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  state_t state, state_next;

  logic [OP_W-1:0]   op_r;
  logic [QSEL_W-1:0] q_r;
  logic [ID_W-1:0]   pid_r;
  logic [PW-1:0]     ptr;
  logic [CW-1:0]     k;

  logic [PW-1:0] head  [QUEUES];
  logic [PW-1:0] tail  [QUEUES];
  logic [CW-1:0] count [QUEUES];

  logic [QW-1:0] q_idx;
  logic          q_ok;
  logic          op_known;
  logic [PW-1:0] cur_head, cur_tail, head_nx, tail_nx, tail_pv, ptr_nx;
  logic [CW-1:0] cur_cnt;
  logic          cnt_zero, cnt_full;
  logic          match, k_last, rm_finish;

  function automatic logic [AW-1:0] addr_of(input logic [QW-1:0] qi, input logic [PW-1:0] p);
    addr_of = AW'(qi) * AW'(DEPTH) + AW'(p);
  endfunction

  function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CW-1:0] c);
    logic [CW+CNT_OUT_W-1:0] w;
    w = (CW + CNT_OUT_W)'(c);
    cnt_out = w[CNT_OUT_W-1:0];
  endfunction

  // addressed queue state and shared step/compare unit
  always_comb begin
    q_idx    = q_r[QW-1:0];
    q_ok     = (int'(q_r) < QUEUES);
    op_known = op_r inside {OP_PUSH, OP_POP, OP_REMOVE, OP_PEEK_F, OP_PEEK_R};
    cur_head = head[q_idx];
    cur_tail = tail[q_idx];
    cur_cnt  = count[q_idx];
    cnt_zero = (cur_cnt == '0);
    cnt_full = (cur_cnt == CNT_FULL);
    head_nx  = (cur_head == PTR_LAST) ? '0 : cur_head + PW'(1);
    tail_nx  = (cur_tail == PTR_LAST) ? '0 : cur_tail + PW'(1);
    tail_pv  = (cur_tail == '0) ? PTR_LAST : cur_tail - PW'(1);
    ptr_nx   = (ptr == PTR_LAST) ? '0 : ptr + PW'(1);
    match    = (rd_data == pid_r);
    k_last   = ({1'b0, k} + (CW + 1)'(1)) >= {1'b0, cur_cnt};
    rm_finish = ((state == S_SCAN) && match && k_last) || ((state == S_SH_WR) && k_last);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (!q_ok || !op_known || op_r == OP_PUSH || cnt_zero) state_next = S_DONE;
        else if (op_r == OP_REMOVE) state_next = S_SCAN;
        else state_next = S_READ;
      end
      S_READ: state_next = S_DONE;
      S_SCAN: begin
        if (match) state_next = k_last ? S_DONE : S_SH_RD;
        else if (k_last) state_next = S_DONE;
      end
      S_SH_RD: state_next = S_SH_WR;
      S_SH_WR: begin
        state_next = k_last ? S_DONE : S_SH_RD;
      end
      S_DONE: begin
        if (res_take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and memory port controls
  always_comb begin
    in_ready = 1'b0;
    done     = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = addr_of(q_idx, ptr_nx);
    wr_en    = 1'b0;
    wr_addr  = addr_of(q_idx, ptr);
    wr_data  = rd_data;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_DECODE: begin
        if (q_ok && op_r == OP_PUSH && !cnt_full) begin
          wr_en   = 1'b1;
          wr_addr = addr_of(q_idx, tail_nx);
          wr_data = pid_r;
        end
        if (q_ok && !cnt_zero) begin
          if (op_r inside {OP_POP, OP_REMOVE, OP_PEEK_F}) begin
            rd_en   = 1'b1;
            rd_addr = addr_of(q_idx, cur_head);
          end else if (op_r == OP_PEEK_R) begin
            rd_en   = 1'b1;
            rd_addr = addr_of(q_idx, cur_tail);
          end
        end
      end
      S_SCAN: rd_en = !match && !k_last;
      S_SH_RD: rd_en = 1'b1;
      S_SH_WR: wr_en = 1'b1;
      S_DONE: done = 1'b1;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-queue pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        head[i]  <= '0;
        tail[i]  <= PTR_LAST;
        count[i] <= '0;
      end
    end else begin
      if (state == S_DECODE && q_ok && op_r == OP_PUSH && !cnt_full) begin
        tail[q_idx]  <= tail_nx;
        count[q_idx] <= cur_cnt + CW'(1);
      end
      if (state == S_READ && op_r == OP_POP) begin
        head[q_idx]  <= head_nx;
        count[q_idx] <= cur_cnt - CW'(1);
      end
      if (rm_finish) begin
        tail[q_idx]  <= tail_pv;
        count[q_idx] <= cur_cnt - CW'(1);
      end
    end
  end

  // request latch, walk pointer and result fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r  <= in_req.op;
          q_r   <= in_req.queue_sel;
          pid_r <= in_req.proc_id;
        end
      end
      S_DECODE: begin
        ptr <= cur_head;
        k   <= '0;
        if (!q_ok) begin
          // missing queue: empty and without room at once
          res.id_out    <= '0;
          res.count_out <= '0;
          if (op_r == OP_PUSH) res.status <= ST_FULL;
          else if (op_known) res.status <= ST_EMPTY;
          else res.status <= ST_OK;
        end else if (op_r == OP_PUSH && !cnt_full) begin
          res.status    <= ST_OK;
          res.id_out    <= pid_r;
          res.count_out <= cnt_out(cur_cnt + CW'(1));
        end else begin
          res.id_out    <= '0;
          res.count_out <= cnt_out(cur_cnt);
          if (op_r == OP_PUSH) res.status <= ST_FULL;
          else if (op_known && cnt_zero) res.status <= ST_EMPTY;
          else res.status <= ST_OK;
        end
      end
      S_READ: begin
        res.id_out <= rd_data;
        if (op_r == OP_POP) res.count_out <= cnt_out(cur_cnt - CW'(1));
      end
      S_SCAN: begin
        if (match) begin
          k <= k + CW'(1);
        end else if (k_last) begin
          res.status <= ST_NOTFOUND;
        end else begin
          ptr <= ptr_nx;
          k   <= k + CW'(1);
        end
      end
      S_SH_WR: begin
        ptr <= ptr_nx;
        k   <= k + CW'(1);
      end
      default: ;
    endcase
    // remove completes: report the id and the shrunken count
    if (rm_finish) begin
      res.id_out    <= pid_r;
      res.count_out <= cnt_out(cur_cnt - CW'(1));
    end
  end

endmodule

// ===== hdl/multi_level_ring_queue_with_remove_top.sv =====
// top level: multilevel ring queues of process ids with remove by id
//
// Requests arrive on the req channel (op, queue_sel, proc_id) and each one
// yields exactly one result on the rsp channel (status, id_out, count_out).
// Both channels move a request when valid and ready are high at a clock edge.
// One request is worked on at a time; req.ready is high only while the
// sequencer is idle. Push, a rejected request or an unknown operation goes
// from decode straight to done; pop and peek first read the id store.
// Remove walks the queue from the head through the single read port of the
// id store, one entry per cycle while searching, then moves each entry behind
// the match toward the head with a read and a write; the walk is longest
// when the id sits at the head. The result sits in an output register; the
// next request is accepted while it waits, and the sequencer holds its own
// finished result until the output register is free, so a stalled receiver
// stalls the block.
// Synchronous reset empties every queue at once; the id store needs no
// clearing since only occupied entries are ever read.
module multi_level_ring_queue_with_remove_top #(
  parameter int QUEUES = mlrq_pkg::QUEUES_DEF,
  parameter int DEPTH  = mlrq_pkg::DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  mlrq_req_if.sink    req,
  mlrq_rsp_if.source  rsp
);
  import mlrq_pkg::*;

  localparam int ENTRIES = QUEUES * DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  req_t            in_req;
  rsp_t            res;
  logic            done;
  logic            res_take;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [ID_W-1:0] rd_data, wr_data;

  // request payload bundle
  always_comb begin
    in_req.op        = req.op;
    in_req.queue_sel = req.queue_sel;
    in_req.proc_id   = req.proc_id;
  end

  mlrq_seq #(.QUEUES(QUEUES), .DEPTH(DEPTH)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_req   (in_req),
    .done     (done),
    .res      (res),
    .res_take (res_take),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  mlrq_store #(.ENTRIES(ENTRIES)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register loads when empty or being drained
  assign res_take = done && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp.status    <= res.status;
      rsp.id_out    <= res.id_out;
      rsp.count_out <= res.count_out;
    end
  end

  // an accepted request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while previous one in progress");

  // failed requests carry no id
  a_fail_no_id: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.id_out == '0)
    else $error("nonzero id on failed request");

  // an empty report always comes with a zero count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_EMPTY |-> rsp.count_out == '0)
    else $error("empty status with nonzero count");

  // a result is only loaded from a finished sequencer
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    res_take |-> !req.ready)
    else $error("result loaded while sequencer idle");

endmodule
